[src/bounce_slot_pool_allocator_unit_defines.svh]
// Assertion macros for the slot pool allocator.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef BOUNCE_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define BOUNCE_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bspa_pkg.sv]
// Shared constants, request codes and controller/datapath structs for the
// slot pool allocator. No dependencies.
`default_nettype none

package bspa_pkg;

	localparam int MAX_SLOTS = 64;

	// Field widths of the stream payloads
	localparam int KIND_W  = 3;
	localparam int IDX_FW  = 7;
	localparam int AMT_FW  = 7;
	localparam int SLOT_FW = 6;
	localparam int CNT_FW  = 7;

	// Request beat: kind in tuser, remaining fields in tdata
	localparam int IDX_LSB  = 0;
	localparam int AMT_LSB  = IDX_LSB + IDX_FW;
	localparam int MIN_LSB  = AMT_LSB + AMT_FW;
	localparam int PVAL_LSB = MIN_LSB + AMT_FW;
	localparam int S_DATA_W = ((PVAL_LSB + 1 + 7) / 8) * 8;

	// Result beat
	localparam int ST_LSB    = 0;
	localparam int SLOT_LSB  = ST_LSB + 1;
	localparam int ACT_LSB   = SLOT_LSB + SLOT_FW;
	localparam int ALLOC_LSB = ACT_LSB + CNT_FW;
	localparam int FREE_LSB  = ALLOC_LSB + CNT_FW;
	localparam int PF_LSB    = FREE_LSB + CNT_FW;
	localparam int M_DATA_W  = ((PF_LSB + 1 + 7) / 8) * 8;

	// Internal sizing
	localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
	localparam int WIDE_W  = ((CNT_W > AMT_FW) ? CNT_W : AMT_FW) + 1;
	localparam int CHUNK   = 8;
	localparam int CHUNK_B = $clog2(CHUNK);
	localparam int NCHUNK  = (MAX_SLOTS + CHUNK - 1) / CHUNK;
	localparam int PAD     = NCHUNK * CHUNK;
	localparam int PAD_W   = $clog2(PAD);
	localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ACQUIRE   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MARK      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXPAND    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SHRINK    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CONSTRUCT = 3'd5;
	localparam logic [KIND_W-1:0] KIND_DESTROY   = 3'd6;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic scan_step;
		logic trim_step;
		logic chunk_clr;
		logic count_step;
		logic load_out;
	} bspa_cmd_t;

	typedef struct packed {
		logic is_acquire;
		logic is_shrink;
		logic scan_hit;
		logic chunk_last;
		logic trim_more;
	} bspa_sts_t;

endpackage

`default_nettype wire

[src/bounce_slot_pool_allocator_unit.sv]
// Slot pool allocator, top level: stream ports, controller and datapath.
// Depends on bspa_pkg, bspa_ctrl, bspa_dp and the assertion macro header.
//
// Usage: one request beat in on s_axis, one result beat out on m_axis.
// The request kind rides in s_axis_tuser; the other fields ride in s_axis_tdata.
// Requests are handled one at a time. After the accepting edge the controller
// steps through EXEC, then SCAN for acquire or TRIM for shrink, then COUNT and
// DONE; the result beat shows on m_axis once DONE finds the result register free.
// The busy bitmap is walked eight slots per cycle, once for the acquire search
// and once for the free count, and the tail trim removes one slot per cycle;
// these loops set how long a request takes. A new request is taken once the
// previous one has moved into the result register, so one stalled result beat
// does not block the next request; the block then waits with the next result
// until m_axis_tready drains the register. Reset clears all slots and counts and
// leaves the pool unconstructed; no clearing pass is needed afterward.
`default_nettype none
`include "bounce_slot_pool_allocator_unit_defines.svh"

module bounce_slot_pool_allocator_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// [6:0] slot_index, [13:7] amount, [20:14] min_amount, [21] posted_value
	input  wire  [bspa_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// [2:0] kind
	input  wire  [bspa_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [0] status, [6:1] slot, [13:7] active_slots, [20:14] allocated_slots,
	// [27:21] free_slots, [28] posted_flag
	output logic [bspa_pkg::M_DATA_W-1:0]    m_axis_tdata
);

	bspa_pkg::bspa_cmd_t cmd;
	bspa_pkg::bspa_sts_t sts;

	// Sequencer: accepts a beat in idle, steps the datapath, owns m_axis_tvalid
	bspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Bitmaps, counts and the result register
	bspa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.in_kind  (s_axis_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_axis_tdata)
	);

	// Count fields of the result beat, for the checks below
	logic [bspa_pkg::CNT_FW-1:0] res_active;
	logic [bspa_pkg::CNT_FW-1:0] res_alloc;
	logic [bspa_pkg::CNT_FW-1:0] res_free;

	assign res_active = m_axis_tdata[bspa_pkg::ACT_LSB +: bspa_pkg::CNT_FW];
	assign res_alloc  = m_axis_tdata[bspa_pkg::ALLOC_LSB +: bspa_pkg::CNT_FW];
	assign res_free   = m_axis_tdata[bspa_pkg::FREE_LSB +: bspa_pkg::CNT_FW];

	// One request in flight: no second beat right after an accepted one
	`BSPA_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat accepted while busy")

	// Never overwrite a result the receiver has not taken
	`BSPA_ASSERT_IMP(a_no_overwrite, cmd.load_out, !m_axis_tvalid || m_axis_tready, "result overwritten")

	// Active count never exceeds the allocated count
	`BSPA_ASSERT_IMP(a_active_le_alloc, m_axis_tvalid, res_active <= res_alloc, "active above allocated")

	// Free slots are counted below the active count only
	`BSPA_ASSERT_IMP(a_free_le_active, m_axis_tvalid, res_free <= res_active, "free above active")

endmodule

`default_nettype wire

[src/bspa_ctrl.sv]
// Sequencing state machine for the slot pool allocator.
// Depends on bspa_pkg; drives the datapath through bspa_cmd_t.
`default_nettype none

module bspa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output bspa_pkg::bspa_cmd_t cmd,
	input  bspa_pkg::bspa_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_TRIM  = 3'd3;
	localparam logic [2:0] ST_COUNT = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.chunk_clr = 1'b1;
				if (sts.is_acquire) begin
					state_d = ST_SCAN;
				end else if (sts.is_shrink) begin
					state_d = ST_TRIM;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.chunk_last) begin
					cmd.chunk_clr = 1'b1;
					state_d       = ST_COUNT;
				end
			end
			ST_TRIM: begin
				if (sts.trim_more) begin
					cmd.trim_step = 1'b1;
				end else begin
					cmd.chunk_clr = 1'b1;
					state_d       = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count_step = 1'b1;
				if (sts.chunk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[src/bspa_dp.sv]
// Datapath of the slot pool allocator: request register, busy/posted bitmaps,
// counts, chunked search and count, result register. Depends on bspa_pkg.
`default_nettype none

module bspa_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  [bspa_pkg::S_DATA_W-1:0]      in_data,
	input  wire  [bspa_pkg::KIND_W-1:0]        in_kind,
	input  bspa_pkg::bspa_cmd_t                cmd,
	output bspa_pkg::bspa_sts_t                sts,
	output logic [bspa_pkg::M_DATA_W-1:0]      out_data
);

	localparam int WW = bspa_pkg::WIDE_W;
	localparam int CW = bspa_pkg::CNT_W;
	localparam int PW = bspa_pkg::PAD_W;
	localparam int CK = bspa_pkg::CHUNK;
	localparam int CB = bspa_pkg::CHUNK_B;
	localparam logic [WW-1:0] MAX_W = WW'(bspa_pkg::MAX_SLOTS);

	// Request register
	logic [bspa_pkg::KIND_W-1:0] kind_q;
	logic [bspa_pkg::IDX_FW-1:0] idx_q;
	logic [bspa_pkg::AMT_FW-1:0] amt_q;
	logic [bspa_pkg::AMT_FW-1:0] min_q;
	logic                        pval_q;

	// Pool state
	logic [bspa_pkg::PAD-1:0] busy_q;
	logic [bspa_pkg::PAD-1:0] posted_q;
	logic [CW-1:0]            alloc_q;
	logic [CW-1:0]            active_q;
	logic                     constructed_q;

	// Per-request working registers
	logic                     status_q;
	logic [PW-1:0]            granted_q;
	logic                     shrink_go_q;
	logic [bspa_pkg::CH_W-1:0] chunk_q;
	logic [CW-1:0]            free_q;
	logic [bspa_pkg::M_DATA_W-1:0] out_q;

	logic [WW-1:0] idx_w, amt_w, min_w, alloc_w, active_w, sum_w, mn_w, tgt_w;
	logic [WW-1:0] tail_w;
	logic          idx_ok;
	logic [PW-1:0] idx_p, tail_p;

	logic [CK-1:0] busy_chunk, below, avail;
	logic [CB-1:0] sel;
	logic [CB:0]   pop;
	logic [PW-1:0] hit_pos;

	always_comb begin
		idx_w    = WW'(idx_q);
		amt_w    = WW'(amt_q);
		min_w    = WW'(min_q);
		alloc_w  = WW'(alloc_q);
		active_w = WW'(active_q);
		sum_w    = alloc_w + amt_w;
		mn_w     = (min_w == '0) ? WW'(1) : min_w;
		tgt_w    = (amt_w < mn_w) ? mn_w : amt_w;
		tail_w   = alloc_w - WW'(1);
		idx_ok   = idx_w < alloc_w;
		idx_p    = idx_w[PW-1:0];
		tail_p   = tail_w[PW-1:0];
	end

	// Current chunk: lowest free slot below the active count, and its popcount
	always_comb begin
		busy_chunk = busy_q[int'(chunk_q) * CK +: CK];
		for (int j = 0; j < CK; j++) begin
			below[j] = WW'({chunk_q, CB'(j)}) < active_w;
		end
		avail = ~busy_chunk & below;
		sel   = '0;
		for (int j = CK - 1; j >= 0; j--) begin
			if (avail[j]) begin
				sel = CB'(j);
			end
		end
		pop = '0;
		for (int j = 0; j < CK; j++) begin
			pop = pop + (CB + 1)'(avail[j]);
		end
		hit_pos = PW'({chunk_q, sel});
	end

	always_comb begin
		sts.is_acquire = kind_q == bspa_pkg::KIND_ACQUIRE;
		sts.is_shrink  = kind_q == bspa_pkg::KIND_SHRINK;
		sts.scan_hit   = |avail;
		sts.chunk_last = chunk_q == bspa_pkg::CH_W'(bspa_pkg::NCHUNK - 1);
		sts.trim_more  = shrink_go_q && (alloc_q > active_q) &&
			!busy_q[tail_p] && !posted_q[tail_p];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= in_kind;
			idx_q  <= in_data[bspa_pkg::IDX_LSB +: bspa_pkg::IDX_FW];
			amt_q  <= in_data[bspa_pkg::AMT_LSB +: bspa_pkg::AMT_FW];
			min_q  <= in_data[bspa_pkg::MIN_LSB +: bspa_pkg::AMT_FW];
			pval_q <= in_data[bspa_pkg::PVAL_LSB];
		end
	end

	// Pool state and per-request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= '0;
			posted_q      <= '0;
			alloc_q       <= '0;
			active_q      <= '0;
			constructed_q <= 1'b0;
			status_q      <= 1'b0;
			granted_q     <= '0;
			shrink_go_q   <= 1'b0;
			chunk_q       <= '0;
			free_q        <= '0;
		end else begin
			if (cmd.exec) begin
				status_q    <= 1'b0;
				granted_q   <= '0;
				shrink_go_q <= 1'b0;
				case (kind_q)
					bspa_pkg::KIND_ACQUIRE: begin
						status_q <= 1'b1;
					end
					bspa_pkg::KIND_RELEASE: begin
						if (idx_ok) begin
							busy_q[idx_p] <= 1'b0;
						end
					end
					bspa_pkg::KIND_MARK: begin
						if (idx_ok) begin
							posted_q[idx_p] <= pval_q;
						end
					end
					bspa_pkg::KIND_EXPAND: begin
						// slots at or above the allocated count are always clear
						if (amt_w != '0) begin
							if (!constructed_q || sum_w > MAX_W) begin
								status_q <= 1'b1;
							end else begin
								alloc_q  <= sum_w[CW-1:0];
								active_q <= sum_w[CW-1:0];
							end
						end
					end
					bspa_pkg::KIND_SHRINK: begin
						if (active_w > tgt_w) begin
							active_q    <= tgt_w[CW-1:0];
							shrink_go_q <= 1'b1;
						end
					end
					bspa_pkg::KIND_CONSTRUCT: begin
						if (constructed_q || amt_w == '0 || amt_w > MAX_W) begin
							status_q <= 1'b1;
						end else begin
							alloc_q       <= amt_w[CW-1:0];
							active_q      <= amt_w[CW-1:0];
							constructed_q <= 1'b1;
						end
					end
					bspa_pkg::KIND_DESTROY: begin
						busy_q        <= '0;
						posted_q      <= '0;
						alloc_q       <= '0;
						active_q      <= '0;
						constructed_q <= 1'b0;
					end
					default: begin
						status_q <= 1'b1;
					end
				endcase
			end

			if (cmd.scan_step && sts.scan_hit) begin
				busy_q[hit_pos] <= 1'b1;
				granted_q       <= hit_pos;
				status_q        <= 1'b0;
			end

			if (cmd.trim_step) begin
				alloc_q <= tail_w[CW-1:0];
			end

			if (cmd.count_step) begin
				free_q <= ((chunk_q == '0) ? '0 : free_q) + CW'(pop);
			end

			if (cmd.chunk_clr) begin
				chunk_q <= '0;
			end else if (cmd.scan_step || cmd.count_step) begin
				chunk_q <= chunk_q + 1'b1;
			end
		end
	end

	// Result register
	logic [WW-1:0] gran_w, free_w;
	logic [bspa_pkg::M_DATA_W-1:0] out_d;

	always_comb begin
		gran_w = WW'(granted_q);
		free_w = WW'(free_q);
		out_d  = '0;
		out_d[bspa_pkg::ST_LSB]                        = status_q;
		out_d[bspa_pkg::SLOT_LSB  +: bspa_pkg::SLOT_FW] = gran_w[bspa_pkg::SLOT_FW-1:0];
		out_d[bspa_pkg::ACT_LSB   +: bspa_pkg::CNT_FW]  = active_w[bspa_pkg::CNT_FW-1:0];
		out_d[bspa_pkg::ALLOC_LSB +: bspa_pkg::CNT_FW]  = alloc_w[bspa_pkg::CNT_FW-1:0];
		out_d[bspa_pkg::FREE_LSB  +: bspa_pkg::CNT_FW]  = free_w[bspa_pkg::CNT_FW-1:0];
		out_d[bspa_pkg::PF_LSB]                        = idx_ok && posted_q[idx_p];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

[tb/sv/bounce_slot_pool_allocator_unit_test.sv]
// Self-checking bench for the slot pool allocator: directed and random request beats,
// with results checked field by field against an in-bench model of the slot pool.
// Depends on bspa_pkg and bounce_slot_pool_allocator_unit.
`timescale 1ns / 1ps

module bounce_slot_pool_allocator_unit_test;
	import bspa_pkg::*;

	// Kind 7 is not decoded by the block; it must come back as a failure.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	// Hold this many cycles of quiet before calling the run done; covers the
	// longest shrink trim plus the other states of a request.
	localparam int DRAIN_CYCLES = 120;

	// Start the long receiver hold-off once this many results have been checked.
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 300;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_STRIDE, SINK_LAZY} sink_mode_t;

	typedef struct packed {
		logic               status;
		logic [SLOT_FW-1:0] slot;
		logic [CNT_FW-1:0]  active;
		logic [CNT_FW-1:0]  alloc;
		logic [CNT_FW-1:0]  free;
		logic               posted;
	} pool_result_t;

	// Slot pool model plus the queue of results it expects the block to return.
	class slot_pool_scoreboard;
		bit [MAX_SLOTS-1:0] busy;
		bit [MAX_SLOTS-1:0] posted;
		int unsigned        alloc_cnt;
		int unsigned        active_cnt;
		bit                 built;
		pool_result_t       pending[$];
		int unsigned        errors;
		int unsigned        checked;

		function new();
			clear_pool();
			errors  = 0;
			checked = 0;
		endfunction

		function void clear_pool();
			busy       = '0;
			posted     = '0;
			alloc_cnt  = 0;
			active_cnt = 0;
			built      = 1'b0;
		endfunction

		// Apply one accepted request to the pool and queue the result it yields.
		function void note_request(logic [KIND_W-1:0] kind, logic [IDX_FW-1:0] idx,
				logic [AMT_FW-1:0] amt, logic [AMT_FW-1:0] mn, logic pval);
			pool_result_t res;
			int unsigned  floor_cnt;
			int unsigned  target;
			int unsigned  n_free;
			res = '0;
			case (kind)
				KIND_ACQUIRE: begin
					res.status = 1'b1;
					for (int unsigned i = 0; i < active_cnt; i++) begin
						if (!busy[i]) begin
							busy[i]    = 1'b1;
							res.slot   = i[SLOT_FW-1:0];
							res.status = 1'b0;
							break;
						end
					end
				end
				KIND_RELEASE: begin
					if (idx < alloc_cnt)
						busy[idx] = 1'b0;
				end
				KIND_MARK: begin
					if (idx < alloc_cnt)
						posted[idx] = pval;
				end
				KIND_EXPAND: begin
					if (amt != 0) begin
						if (!built || alloc_cnt + amt > MAX_SLOTS) begin
							res.status = 1'b1;
						end else begin
							for (int unsigned i = alloc_cnt; i < alloc_cnt + amt; i++) begin
								busy[i]   = 1'b0;
								posted[i] = 1'b0;
							end
							alloc_cnt  = alloc_cnt + amt;
							active_cnt = alloc_cnt;
						end
					end
				end
				KIND_SHRINK: begin
					floor_cnt = (mn == 0) ? 1 : mn;
					target    = (amt < floor_cnt) ? floor_cnt : amt;
					if (active_cnt > target) begin
						active_cnt = target;
						// trim the tail while it holds neither a busy nor a posted slot
						while (alloc_cnt > active_cnt && !busy[alloc_cnt-1] &&
								!posted[alloc_cnt-1])
							alloc_cnt--;
					end
				end
				KIND_CONSTRUCT: begin
					if (built || amt == 0 || amt > MAX_SLOTS) begin
						res.status = 1'b1;
					end else begin
						busy       = '0;
						posted     = '0;
						alloc_cnt  = amt;
						active_cnt = amt;
						built      = 1'b1;
					end
				end
				KIND_DESTROY: clear_pool();
				default: res.status = 1'b1;
			endcase
			n_free = 0;
			for (int unsigned i = 0; i < active_cnt; i++)
				if (!busy[i])
					n_free++;
			res.active = active_cnt[CNT_FW-1:0];
			res.alloc  = alloc_cnt[CNT_FW-1:0];
			res.free   = n_free[CNT_FW-1:0];
			res.posted = (idx < alloc_cnt) ? posted[idx] : 1'b0;
			pending.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Compare one result beat against the oldest pending expectation.
		task check_result(logic [M_DATA_W-1:0] beat);
			pool_result_t got;
			pool_result_t want;
			checked++;
			got.status = beat[ST_LSB];
			got.slot   = beat[SLOT_LSB +: SLOT_FW];
			got.active = beat[ACT_LSB +: CNT_FW];
			got.alloc  = beat[ALLOC_LSB +: CNT_FW];
			got.free   = beat[FREE_LSB +: CNT_FW];
			got.posted = beat[PF_LSB];
			if (pending.size() == 0) begin
				report($sformatf("result beat 0x%08h with no request pending", beat));
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status)
					report($sformatf("result %0d status %0d, want %0d",
						checked, got.status, want.status));
				if (got.slot !== want.slot)
					report($sformatf("result %0d slot %0d, want %0d",
						checked, got.slot, want.slot));
				if (got.active !== want.active)
					report($sformatf("result %0d active_slots %0d, want %0d",
						checked, got.active, want.active));
				if (got.alloc !== want.alloc)
					report($sformatf("result %0d allocated_slots %0d, want %0d",
						checked, got.alloc, want.alloc));
				if (got.free !== want.free)
					report($sformatf("result %0d free_slots %0d, want %0d",
						checked, got.free, want.free));
				if (got.posted !== want.posted)
					report($sformatf("result %0d posted_flag %0d, want %0d",
						checked, got.posted, want.posted));
			end
		endtask
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [KIND_W-1:0]   s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	slot_pool_scoreboard sb = new();

	// Sender burst state, owned by the stimulus process.
	int unsigned burst_left = 0;

	bounce_slot_pool_allocator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one request beat and hold it until the block takes it. Between bursts,
	// drop tvalid for a random gap so idle cycles land on every phase of the work.
	task automatic send_request(logic [KIND_W-1:0] kind, logic [IDX_FW-1:0] idx,
			logic [AMT_FW-1:0] amt, logic [AMT_FW-1:0] mn, logic pval);
		logic [S_DATA_W-1:0] data;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		data                      = '0;
		data[IDX_LSB +: IDX_FW]   = idx;
		data[AMT_LSB +: AMT_FW]   = amt;
		data[MIN_LSB +: AMT_FW]   = mn;
		data[PVAL_LSB]            = pval;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(kind, idx, amt, mn, pval);
		burst_left--;
	endtask

	// Random requests shaped around a live pool: build it first, then mostly
	// acquire/release/mark traffic with indices inside the pool, plus resizes,
	// teardowns and raw out-of-range noise.
	task automatic run_random_mix(int unsigned count);
		logic [KIND_W-1:0] kind;
		logic [IDX_FW-1:0] idx;
		logic [AMT_FW-1:0] amt;
		logic [AMT_FW-1:0] mn;
		logic              pval;
		int unsigned       roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			idx  = $urandom_range(0, 127);
			amt  = $urandom_range(0, 127);
			mn   = $urandom_range(0, 127);
			pval = $urandom_range(0, 1);
			if (!sb.built) begin
				if (roll < 85) begin
					kind = KIND_CONSTRUCT;
					roll = $urandom_range(0, 99);
					if (roll < 10)
						amt = MAX_SLOTS;
					else if (roll < 30)
						amt = $urandom_range(17, MAX_SLOTS - 1);
					else
						amt = $urandom_range(1, 16);
				end else if (roll < 90) begin
					kind = KIND_CONSTRUCT;
				end else begin
					kind = $urandom_range(0, 7);
				end
			end else begin
				if (sb.alloc_cnt != 0 && $urandom_range(0, 9) != 0)
					idx = $urandom_range(0, sb.alloc_cnt - 1);
				if (roll < 30) begin
					kind = KIND_ACQUIRE;
				end else if (roll < 55) begin
					kind = KIND_RELEASE;
				end else if (roll < 68) begin
					kind = KIND_MARK;
				end else if (roll < 78) begin
					kind = KIND_EXPAND;
					if ($urandom_range(0, 4) != 0)
						amt = $urandom_range(0, 8);
				end else if (roll < 90) begin
					kind = KIND_SHRINK;
					amt  = $urandom_range(0, sb.active_cnt);
					if ($urandom_range(0, 3) != 0)
						mn = $urandom_range(0, 4);
				end else if (roll < 94) begin
					kind = KIND_DESTROY;
				end else if (roll < 97) begin
					kind = KIND_CONSTRUCT;
				end else begin
					kind = KIND_UNUSED;
				end
			end
			send_request(kind, idx, amt, mn, pval);
		end
	endtask

	// Stimulus: reset, directed corner cases, random mix, drain, verdict.
	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unconstructed pool: no grant, zero expand passes, real expand fails
		send_request(KIND_ACQUIRE,   7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_EXPAND,    7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_EXPAND,    7'd3,   7'd5,   7'd0,   1'b1);
		send_request(KIND_SHRINK,    7'd0,   7'd0,   7'd0,   1'b0);
		// construct: zero and oversize fail, full size succeeds, second one fails
		send_request(KIND_CONSTRUCT, 7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_CONSTRUCT, 7'd0,   7'd65,  7'd0,   1'b0);
		send_request(KIND_CONSTRUCT, 7'd63,  7'd64,  7'd0,   1'b0);
		send_request(KIND_CONSTRUCT, 7'd0,   7'd3,   7'd0,   1'b0);
		send_request(KIND_ACQUIRE,   7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_ACQUIRE,   7'd1,   7'd0,   7'd0,   1'b0);
		// mark the top slot posted; out-of-range mark and release are ignored
		send_request(KIND_MARK,      7'd63,  7'd0,   7'd0,   1'b1);
		send_request(KIND_MARK,      7'd127, 7'd0,   7'd0,   1'b1);
		send_request(KIND_RELEASE,   7'd127, 7'd0,   7'd0,   1'b0);
		// expand past capacity fails
		send_request(KIND_EXPAND,    7'd0,   7'd1,   7'd0,   1'b0);
		// shrink blocked at the tail by the posted top slot
		send_request(KIND_SHRINK,    7'd63,  7'd40,  7'd0,   1'b0);
		send_request(KIND_MARK,      7'd63,  7'd0,   7'd0,   1'b0);
		// minimum above the active count: nothing moves
		send_request(KIND_SHRINK,    7'd0,   7'd0,   7'd127, 1'b0);
		// zero target and zero minimum: down to one active, long tail trim
		send_request(KIND_SHRINK,    7'd1,   7'd0,   7'd0,   1'b0);
		send_request(KIND_RELEASE,   7'd1,   7'd0,   7'd0,   1'b0);
		// only slot 0 is active and it is busy: no free slot
		send_request(KIND_ACQUIRE,   7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_EXPAND,    7'd2,   7'd62,  7'd0,   1'b0);
		send_request(KIND_UNUSED,    7'd127, 7'd127, 7'd127, 1'b1);
		send_request(KIND_DESTROY,   7'd0,   7'd0,   7'd0,   1'b0);
		send_request(KIND_CONSTRUCT, 7'd0,   7'd127, 7'd0,   1'b0);
		send_request(KIND_CONSTRUCT, 7'd0,   7'd1,   7'd0,   1'b0);

		run_random_mix(900);
		s_axis_tvalid <= 1'b0;

		// wait for every expected result, then let any stray beat show up
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("** bounce_slot_pool_allocator_unit: PASSED **");
		else
			$display("** bounce_slot_pool_allocator_unit: FAILED **");
		$finish;
	end

	// Receiver: switch between stall patterns at random intervals, and once,
	// after a few hundred results, hold off long enough for the block to back up
	// into its request port.
	initial begin : result_sink
		sink_mode_t  mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          held_once;
		mode      = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && sb.checked >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = sink_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				case (mode)
					SINK_OPEN:   m_axis_tready <= 1'b1;
					SINK_COIN:   m_axis_tready <= $urandom_range(0, 1);
					SINK_STRIDE: m_axis_tready <= (mode_left % 4 == 0);
					default:     m_axis_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Check each result beat as it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#4ms;
		$display("** bounce_slot_pool_allocator_unit: FAILED **");
		$finish;
	end

endmodule
